FILE: sv/infix_to_postfix_converter_assert.svh
// Assertion macros used by the converter control RTL (isp_ctrl).
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define ISP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ISP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ISP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ISP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: sv/isp_pkg.sv
`timescale 1ns / 1ps

package isp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CODE_W      = 3;

  localparam logic [CODE_W-1:0] CODE_OPEN = 3'd5;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_Z      = 8'h7A;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } in_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic       end_of_expression;
    logic       syntax_error;
  } out_t;

  // {is operator, precedence code}
  function automatic logic [CODE_W:0] op_code(input logic [7:0] sym);
    logic [CODE_W:0] r;
    case (sym)
      CH_PLUS:  r = {1'b1, 3'd0};
      CH_MINUS: r = {1'b1, 3'd1};
      CH_STAR:  r = {1'b1, 3'd2};
      CH_SLASH: r = {1'b1, 3'd3};
      CH_CARET: r = {1'b1, 3'd4};
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] op_char(input logic [CODE_W-1:0] code);
    logic [7:0] r;
    case (code)
      3'd0:    r = CH_PLUS;
      3'd1:    r = CH_MINUS;
      3'd2:    r = CH_STAR;
      3'd3:    r = CH_SLASH;
      3'd4:    r = CH_CARET;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/isp_stack_ram.sv
`timescale 1ns / 1ps

module isp_stack_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 3,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/isp_ctrl.sv
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_assert.svh"

module isp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  isp_pkg::in_t  in_data,
  output logic          res_valid,
  input  logic          res_stall,
  output isp_pkg::out_t res_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_AFTER  = 3'd1;
  localparam logic [2:0] S_POPCHK = 3'd2;
  localparam logic [2:0] S_TOP    = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_PUSH   = 3'd5;

  localparam logic [1:0] MODE_CLOSE = 2'd0;
  localparam logic [1:0] MODE_OP    = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  localparam logic [isp_pkg::CNT_W-1:0] CNT_FULL = isp_pkg::CNT_W'(isp_pkg::STACK_DEPTH);

  logic [2:0]                    st_r, st_nxt;
  logic [2:0]                    ret_r, ret_nxt;
  logic [1:0]                    mode_r, mode_nxt;
  logic                          last_r, last_nxt;
  logic [isp_pkg::CODE_W-1:0]    prec_r, prec_nxt;
  logic [isp_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  isp_pkg::out_t                 res_r, res_nxt;

  logic                          ram_we;
  logic                          ram_re;
  logic [isp_pkg::ADDR_W-1:0]    ram_waddr;
  logic [isp_pkg::ADDR_W-1:0]    ram_raddr;
  logic [isp_pkg::CODE_W-1:0]    top_code;
  logic [isp_pkg::CNT_W-1:0]     cnt_dec;
  logic [isp_pkg::CODE_W:0]      in_op;
  logic                          in_accept;

  isp_stack_ram #(
    .DEPTH(isp_pkg::STACK_DEPTH),
    .WIDTH(isp_pkg::CODE_W)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (prec_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (top_code)
  );

  assign in_stall  = (st_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_op     = isp_pkg::op_code(in_data.symbol);
  assign cnt_dec   = cnt_r - 1'b1;
  assign ram_waddr = cnt_r[isp_pkg::ADDR_W-1:0];
  assign ram_raddr = cnt_dec[isp_pkg::ADDR_W-1:0];
  assign res_valid = (st_r == S_EMIT);
  assign res_data  = res_r;

  always_comb begin
    st_nxt   = st_r;
    ret_nxt  = ret_r;
    mode_nxt = mode_r;
    last_nxt = last_r;
    prec_nxt = prec_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_accept) begin
          last_nxt = in_data.last_symbol;
          if (in_data.symbol == isp_pkg::CH_LPAREN) begin
            prec_nxt = isp_pkg::CODE_OPEN;
            st_nxt   = S_PUSH;
          end else if (in_data.symbol inside {[isp_pkg::CH_A:isp_pkg::CH_Z]}) begin
            res_nxt = '{out_symbol: in_data.symbol, has_symbol: 1'b1,
                        end_of_expression: 1'b0, syntax_error: 1'b0};
            ret_nxt = S_AFTER;
            st_nxt  = S_EMIT;
          end else if (in_data.symbol == isp_pkg::CH_RPAREN) begin
            mode_nxt = MODE_CLOSE;
            st_nxt   = S_POPCHK;
          end else if (in_op[isp_pkg::CODE_W]) begin
            prec_nxt = in_op[isp_pkg::CODE_W-1:0];
            mode_nxt = MODE_OP;
            st_nxt   = S_POPCHK;
          end else begin
            st_nxt = S_AFTER;
          end
        end
      end
      S_AFTER: begin
        if (last_r) begin
          mode_nxt = MODE_FLUSH;
          st_nxt   = S_POPCHK;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_POPCHK: begin
        if (cnt_r == '0) begin
          case (mode_r)
            MODE_CLOSE: begin
              res_nxt = '{out_symbol: 8'h00, has_symbol: 1'b0,
                          end_of_expression: 1'b0, syntax_error: 1'b1};
              ret_nxt = S_AFTER;
              st_nxt  = S_EMIT;
            end
            MODE_OP: begin
              st_nxt = S_PUSH;
            end
            default: begin
              res_nxt = '{out_symbol: 8'h00, has_symbol: 1'b0,
                          end_of_expression: 1'b1, syntax_error: 1'b0};
              ret_nxt = S_IDLE;
              st_nxt  = S_EMIT;
            end
          endcase
        end else begin
          ram_re = 1'b1;
          st_nxt = S_TOP;
        end
      end
      S_TOP: begin
        res_nxt = '{out_symbol: isp_pkg::op_char(top_code), has_symbol: 1'b1,
                    end_of_expression: 1'b0, syntax_error: 1'b0};
        case (mode_r)
          MODE_CLOSE: begin
            cnt_nxt = cnt_dec;
            if (top_code == isp_pkg::CODE_OPEN) begin
              st_nxt = S_AFTER;
            end else begin
              ret_nxt = S_POPCHK;
              st_nxt  = S_EMIT;
            end
          end
          MODE_OP: begin
            if (top_code == isp_pkg::CODE_OPEN || prec_r > top_code) begin
              st_nxt = S_PUSH;
            end else begin
              cnt_nxt = cnt_dec;
              ret_nxt = S_POPCHK;
              st_nxt  = S_EMIT;
            end
          end
          default: begin
            cnt_nxt = cnt_dec;
            if (top_code < isp_pkg::CODE_OPEN) begin
              ret_nxt = S_POPCHK;
              st_nxt  = S_EMIT;
            end else begin
              st_nxt = S_POPCHK;
            end
          end
        endcase
      end
      S_PUSH: begin
        if (cnt_r >= CNT_FULL) begin
          res_nxt = '{out_symbol: 8'h00, has_symbol: 1'b0,
                      end_of_expression: 1'b0, syntax_error: 1'b1};
          ret_nxt = S_AFTER;
          st_nxt  = S_EMIT;
        end else begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          st_nxt  = S_AFTER;
        end
      end
      S_EMIT: begin
        if (!res_stall) begin
          st_nxt = ret_r;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r  <= ret_nxt;
    mode_r <= mode_nxt;
    last_r <= last_nxt;
    prec_r <= prec_nxt;
    res_r  <= res_nxt;
  end

  `ISP_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_FULL, "stack count beyond depth")
  `ISP_ASSERT(a_rw_apart, clk, rst_n, !(ram_we && ram_re), "stack read and write collide")
  `ISP_ASSERT(a_push_room, clk, rst_n, ram_we |-> cnt_r < CNT_FULL, "push into full stack")
  `ISP_ASSERT(a_read_nonempty, clk, rst_n, ram_re |-> cnt_r != '0, "read of empty stack")
  `ISP_ASSERT(a_accept_busy, clk, rst_n, in_accept |=> in_stall, "accepted while busy")

endmodule

FILE: sv/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// An accepted letter is registered in the control's EMIT state, then in the output
// register that drives out_valid; out_stall can hold it in EMIT. in_stall is high
// until the control is idle again; each stack top read passes POPCHK and the RAM
// read into TOP, each result passes EMIT; the last item adds a flush and end marker.
// Reset: rst_n clears stack count, control state and out_valid; RAM is not cleared.

module infix_to_postfix_converter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  isp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output isp_pkg::out_t out_data
);

  logic          res_valid;
  logic          res_stall;
  isp_pkg::out_t res_data;
  logic          load;
  logic          out_valid_r, out_valid_nxt;
  isp_pkg::out_t out_data_r;

  isp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  assign res_stall     = out_valid_r && out_stall;
  assign load          = res_valid && !res_stall;
  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
